### hdl/tift_pkg.sv
// Package: shared types, constants and command codes for the tone table.
package tift_pkg;
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [14:0] STEP_START = 15'd1000;
  localparam logic [14:0] STEP_FLOOR = 15'd20;

  localparam logic [2:0] CMD_SET   = 3'd0;
  localparam logic [2:0] CMD_IDENT = 3'd1;
  localparam logic [2:0] CMD_FREQ  = 3'd2;
  localparam logic [2:0] CMD_STEP  = 3'd3;
  localparam logic [2:0] CMD_COUNT = 3'd4;
  localparam logic [2:0] CMD_CLEAR = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LOW   = 2'd1;
  localparam logic [1:0] ST_HIGH  = 2'd2;
  localparam logic [1:0] ST_IDENT = 2'd3;

  localparam logic [1:0] REG_BORDER = 2'd0;
  localparam logic [1:0] REG_FMIN   = 2'd1;
  localparam logic [1:0] REG_FMAX   = 2'd2;
  localparam logic [1:0] REG_NLIM   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_RELOC, S_EXEC, S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic reloc;
    logic exec;
  } ctrl_t;

  typedef struct packed {
    logic scan_last;
  } stat_t;
endpackage

### hdl/tone_id_frequency_table.sv
// Top level: tone identifier and frequency table with APB register port.
//
//  channel | handshake         | payload
//  input   | in_valid/in_stall | cmd, ident, frequency
//  output  | out_valid/out_stall | status, value
//  config  | APB write/read    | match_border, freq_min, freq_max, num_limit
//
// Each item passes through a load step, a serial scan of the table,
// a second serial pass to locate the relocation slot, an execute step,
// then the result register.
// Reset is synchronous; it clears valid bits and the write count at once.
// A stalled result holds the block; the next item waits until it is taken.
module tone_id_frequency_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [15:0] ident,
  input  logic [15:0] frequency,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [14:0] value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tift_pkg::*;
  ctrl_t ctrl;
  stat_t stat;
  logic [11:0] match_border;
  logic [14:0] freq_min, freq_max, num_limit;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  // hold register values; write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      match_border <= 12'd16;
      freq_min <= 15'd1000;
      freq_max <= 15'd8000;
      num_limit <= 15'd255;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        REG_BORDER: match_border <= pwdata[11:0];
        REG_FMIN:   freq_min <= pwdata[14:0];
        REG_FMAX:   freq_max <= pwdata[14:0];
        REG_NLIM:   num_limit <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BORDER: prdata = {20'd0, match_border};
      REG_FMIN:   prdata = {17'd0, freq_min};
      REG_FMAX:   prdata = {17'd0, freq_max};
      REG_NLIM:   prdata = {17'd0, num_limit};
      default:    prdata = '0;
    endcase
  end

  tift_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .ctrl
  );

  tift_dp u_dp (
    .clk, .rst, .ctrl, .stat, .cmd, .ident, .frequency,
    .match_border, .freq_min, .freq_max, .num_limit, .status, .value
  );
endmodule

### hdl/tift_ctrl.sv
// Controller: sequences load, table scan, relocation search and execute.
module tift_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  tift_pkg::stat_t stat,
  output tift_pkg::ctrl_t ctrl
);
  import tift_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_SCAN;
      S_SCAN:  if (stat.scan_last) state_next = S_RELOC;
      S_RELOC: if (stat.scan_last) state_next = S_EXEC;
      S_EXEC:  state_next = S_DONE;
      S_DONE:  if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    in_stall = (state != S_IDLE);
    out_valid = (state == S_DONE);
    case (state)
      S_IDLE:  ctrl.load = in_valid;
      S_SCAN:  ctrl.scan = 1'b1;
      S_RELOC: ctrl.reloc = 1'b1;
      S_EXEC:  ctrl.exec = 1'b1;
      default: ;
    endcase
  end
endmodule

### hdl/tift_dp.sv
// Datapath: table storage, serial scan units and result register.
module tift_dp (
  input  logic clk,
  input  logic rst,
  input  tift_pkg::ctrl_t ctrl,
  output tift_pkg::stat_t stat,
  input  logic [2:0]  cmd,
  input  logic [15:0] ident,
  input  logic [15:0] frequency,
  input  logic [11:0] match_border,
  input  logic [14:0] freq_min,
  input  logic [14:0] freq_max,
  input  logic [14:0] num_limit,
  output logic [1:0]  status,
  output logic [14:0] value
);
  import tift_pkg::*;
  logic [14:0] fmem [TABLE_DEPTH];
  logic [14:0] imem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld;
  logic [CNT_W-1:0] write_count;

  logic [2:0] r_cmd;
  logic [15:0] r_id, r_fq;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] rd_addr;
  logic [14:0] f_rd, i_rd;
  logic v_rd;
  logic [14:0] f_cur, i_cur, f_prev;
  logic hit_near, hit_id, hit_sf;
  logic [14:0] near_ident, sf, step, r_sn;
  logic [IDX_W-1:0] slot;
  logic slot_hit;
  logic [CNT_W-1:0] cnt;
  logic [1:0] chk;

  // fetch one entry ahead so the entry at idx is in the read register
  assign rd_addr = ctrl.load ? '0 : idx + 1'b1;

  always_ff @(posedge clk) begin
    f_rd <= fmem[rd_addr];
    i_rd <= imem[rd_addr];
    v_rd <= vld[rd_addr];
  end

  assign f_cur = v_rd ? f_rd : 15'd0;
  assign i_cur = v_rd ? i_rd : 15'd0;
  assign stat.scan_last = (idx == IDX_W'(TABLE_DEPTH - 1));

  logic signed [17:0] lo, hi, fs;
  logic near_now;
  logic [14:0] diff;
  logic [14:0] key_f;
  logic relo_now;
  assign lo = $signed({2'b0, r_fq}) - $signed({6'b0, match_border});
  assign hi = $signed({2'b0, r_fq}) + $signed({6'b0, match_border});
  assign fs = $signed({3'b0, f_cur});
  assign near_now = (fs > lo) && (fs < hi);
  assign diff = (f_cur > f_prev) ? f_cur - f_prev : f_prev - f_cur;
  // relocation pass searches by frequency when the ident hit gave one
  assign key_f = sf;
  assign relo_now = hit_sf ? (f_cur == key_f) : (i_cur == r_sn);

  always_comb begin
    if (r_fq < {1'b0, freq_min}) chk = ST_LOW;
    else if (r_fq > {1'b0, freq_max}) chk = ST_HIGH;
    else if (r_id > {1'b0, num_limit}) chk = ST_IDENT;
    else chk = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      write_count <= '0;
    end else if (ctrl.exec) begin
      if (r_cmd == CMD_CLEAR) begin
        vld <= '0;
        write_count <= '0;
      end else if (r_cmd == CMD_SET && chk == ST_OK) begin
        vld[slot] <= 1'b1;
        if (write_count < CNT_W'(TABLE_DEPTH)) write_count <= write_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec && r_cmd == CMD_SET && chk == ST_OK) begin
      fmem[slot] <= r_fq[14:0];
      imem[slot] <= r_id[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      r_cmd <= cmd; r_id <= ident; r_fq <= frequency;
      idx <= '0; hit_near <= 1'b0; hit_id <= 1'b0;
      near_ident <= '0; sf <= '0; step <= STEP_START; cnt <= '0;
      f_prev <= '0; slot_hit <= 1'b0;
    end else if (ctrl.scan) begin
      idx <= idx + 1'b1;
      f_prev <= f_cur;
      if (!hit_near && near_now) begin
        hit_near <= 1'b1; near_ident <= i_cur;
      end
      if (!hit_id && {1'b0, i_cur} == r_id) begin
        hit_id <= 1'b1; sf <= f_cur;
      end
      if (f_cur != 15'd0) cnt <= cnt + 1'b1;
      if (idx != '0 && {1'b0, idx} < write_count && diff >= STEP_FLOOR && diff < step)
        step <= diff;
      if (stat.scan_last) begin
        hit_sf <= (hit_id ? sf : ({1'b0, i_cur} == r_id ? f_cur : 15'd0)) != 15'd0;
        if (!hit_id && {1'b0, i_cur} == r_id) sf <= f_cur;
        r_sn <= hit_near ? near_ident : (near_now ? i_cur : 15'd0);
        slot <= (write_count < CNT_W'(TABLE_DEPTH)) ? write_count[IDX_W-1:0] : '0;
      end
    end else if (ctrl.reloc) begin
      idx <= idx + 1'b1;
      if (!slot_hit && (hit_sf || r_sn != 15'd0)) begin
        if (relo_now) begin
          slot_hit <= 1'b1; slot <= idx;
        end else if (stat.scan_last) slot <= '0;
      end
    end else if (ctrl.exec) begin
      status <= ST_OK;
      value <= '0;
      case (r_cmd)
        CMD_SET: status <= chk;
        CMD_IDENT:
          if (chk == ST_LOW || chk == ST_HIGH) status <= chk;
          else value <= near_ident;
        CMD_FREQ:
          if (r_id > {1'b0, num_limit}) status <= ST_IDENT;
          else value <= sf;
        CMD_STEP: value <= step;
        CMD_COUNT: value <= 15'(cnt);
        default: ;
      endcase
    end
  end
endmodule

### hdl/tift_checker.sv
// Checker: port-level properties of the tone table, bound to the top level.
module tift_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [1:0] status,
  input logic [14:0] value
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_noout: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid) else $error("result too early");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
endmodule

bind tone_id_frequency_table tift_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .status, .value
);
